FILE: rtl/core/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared types and address map constants for the banked memory map decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmmd_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned RegionW = 4;
  localparam int unsigned WbankW  = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgColorMode = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBankCtrl  = 1'd1;

  // address map boundaries
  localparam logic [AddrW-1:0] BootLowEnd   = 16'h00FF;
  localparam logic [AddrW-1:0] BootHighBase = 16'h0200;
  localparam logic [AddrW-1:0] BootHighEnd  = 16'h08FF;
  localparam logic [AddrW-1:0] RomEnd       = 16'h7FFF;
  localparam logic [AddrW-1:0] VramEnd      = 16'h9FFF;
  localparam logic [AddrW-1:0] ExtRamEnd    = 16'hBFFF;
  localparam logic [AddrW-1:0] Wram0End     = 16'hCFFF;
  localparam logic [AddrW-1:0] Wram1End     = 16'hDFFF;
  localparam logic [AddrW-1:0] EchoBase     = 16'hE000;
  localparam logic [AddrW-1:0] EchoEnd      = 16'hFDFF;
  localparam logic [AddrW-1:0] EchoFold     = 16'h2000;
  localparam logic [AddrW-1:0] OamBase      = 16'hFE00;
  localparam logic [AddrW-1:0] OamEnd       = 16'hFE9F;
  localparam logic [AddrW-1:0] IoBase       = 16'hFF00;
  localparam logic [AddrW-1:0] IoEnd        = 16'hFF7F;
  localparam logic [AddrW-1:0] HramBase     = 16'hFF80;
  localparam logic [AddrW-1:0] HramEnd      = 16'hFFFE;
  localparam logic [AddrW-1:0] IeAddr       = 16'hFFFF;

  typedef enum logic [RegionW-1:0] {
    RG_BOOT_BASE  = 4'd0,
    RG_BOOT_COLOR = 4'd1,
    RG_CART_ROM   = 4'd2,
    RG_BANK_CTRL  = 4'd3,
    RG_VRAM       = 4'd4,
    RG_EXT_RAM    = 4'd5,
    RG_WRAM       = 4'd6,
    RG_IO         = 4'd7,
    RG_OAM        = 4'd8,
    RG_HRAM       = 4'd9,
    RG_IE         = 4'd10,
    RG_DROPPED    = 4'd11,
    RG_INVALID    = 4'd12
  } region_e;

  typedef struct packed {
    logic color_mode;
    logic bank_ctrl_present;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/bmmd_decode.sv
// ----------------------------------------------------------------------------
// bmmd_decode
// Address to region/offset decode for one bus request, no storage.
// ----------------------------------------------------------------------------
`default_nettype none

module bmmd_decode (
  input  bmmd_pkg::cfg_t                      cfg_i,
  input  logic                                req_type_i,
  input  logic [bmmd_pkg::AddrW-1:0]          addr_i,
  input  logic                                boot_overlay_on_i,
  input  logic                                vram_bank_i,
  input  logic [bmmd_pkg::WbankW-1:0]         wram_bank_i,
  output bmmd_pkg::region_e                   region_o,
  output logic [bmmd_pkg::OffsetW-1:0]        offset_o,
  output logic                                error_o
);

  logic [bmmd_pkg::AddrW-1:0]  a;
  logic                        vbank;
  logic [bmmd_pkg::WbankW-1:0] wbank;

  // fold the echo area down onto work RAM
  always_comb begin
    if (addr_i >= bmmd_pkg::EchoBase && addr_i <= bmmd_pkg::EchoEnd) begin
      a = addr_i - bmmd_pkg::EchoFold;
    end else begin
      a = addr_i;
    end
  end

  assign vbank = cfg_i.color_mode & vram_bank_i;

  // bank 0 reads as bank 1; outside color mode always bank 1
  always_comb begin
    if (!cfg_i.color_mode || wram_bank_i == '0) begin
      wbank = bmmd_pkg::WbankW'(1);
    end else begin
      wbank = wram_bank_i;
    end
  end

  always_comb begin
    region_o = bmmd_pkg::RG_INVALID;
    offset_o = '0;
    error_o  = 1'b0;
    if (boot_overlay_on_i && a <= bmmd_pkg::BootLowEnd) begin
      region_o = cfg_i.color_mode ? bmmd_pkg::RG_BOOT_COLOR : bmmd_pkg::RG_BOOT_BASE;
      offset_o = a;
    end else if (boot_overlay_on_i && cfg_i.color_mode &&
                 a >= bmmd_pkg::BootHighBase && a <= bmmd_pkg::BootHighEnd) begin
      region_o = bmmd_pkg::RG_BOOT_COLOR;
      offset_o = a;
    end else if (a <= bmmd_pkg::RomEnd) begin
      if (cfg_i.bank_ctrl_present) begin
        region_o = bmmd_pkg::RG_BANK_CTRL;
        offset_o = a;
      end else if (req_type_i) begin
        // drop ROM writes with no controller behind them
        region_o = bmmd_pkg::RG_DROPPED;
        offset_o = '0;
      end else begin
        region_o = bmmd_pkg::RG_CART_ROM;
        offset_o = a;
      end
    end else if (a <= bmmd_pkg::VramEnd) begin
      region_o = bmmd_pkg::RG_VRAM;
      offset_o = {2'b00, vbank, a[12:0]};
    end else if (a <= bmmd_pkg::ExtRamEnd) begin
      if (cfg_i.bank_ctrl_present) begin
        region_o = bmmd_pkg::RG_BANK_CTRL;
        offset_o = a;
      end else begin
        region_o = bmmd_pkg::RG_EXT_RAM;
        offset_o = {3'b000, a[12:0]};
      end
    end else if (a <= bmmd_pkg::Wram0End) begin
      region_o = bmmd_pkg::RG_WRAM;
      offset_o = {4'b0000, a[11:0]};
    end else if (a <= bmmd_pkg::Wram1End) begin
      region_o = bmmd_pkg::RG_WRAM;
      offset_o = {1'b0, wbank, a[11:0]};
    end else if (a >= bmmd_pkg::OamBase && a <= bmmd_pkg::OamEnd) begin
      region_o = bmmd_pkg::RG_OAM;
      offset_o = {8'h00, a[7:0]};
    end else if (a >= bmmd_pkg::IoBase && a <= bmmd_pkg::IoEnd) begin
      region_o = bmmd_pkg::RG_IO;
      offset_o = {8'h00, a[7:0]};
    end else if (a >= bmmd_pkg::HramBase && a <= bmmd_pkg::HramEnd) begin
      region_o = bmmd_pkg::RG_HRAM;
      offset_o = {9'h000, a[6:0]};
    end else if (a == bmmd_pkg::IeAddr) begin
      region_o = bmmd_pkg::RG_IE;
      offset_o = '0;
    end else begin
      region_o = bmmd_pkg::RG_INVALID;
      offset_o = '0;
      error_o  = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/banked_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// banked_memory_map_decoder
// Two-stage decoder: request register, address decode, result register.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_stall_o is low. An accepted request is
// held in the request register and moves into the result register, which
// presents it, once that register is empty or its result is being taken. The
// whole decode sits between those two registers. While the result register
// holds an untaken result, one more request is still taken into the request
// register; stall goes up only when both stages are full and the output is
// stalled. Configuration writes take effect on the next request decoded.
`default_nettype none

module banked_memory_map_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bmmd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bmmd_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [bmmd_pkg::AddrW-1:0]        addr_i,
  input  logic                              boot_overlay_on_i,
  input  logic                              vram_bank_i,
  input  logic [bmmd_pkg::WbankW-1:0]       wram_bank_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bmmd_pkg::RegionW-1:0]      region_o,
  output logic [bmmd_pkg::OffsetW-1:0]      offset_o,
  output logic                              error_o
);

  bmmd_pkg::cfg_t cfg_q;

  logic                         req_valid_q;
  logic                         req_type_q;
  logic [bmmd_pkg::AddrW-1:0]   addr_q;
  logic                         boot_q;
  logic                         vbank_q;
  logic [bmmd_pkg::WbankW-1:0]  wbank_q;

  logic                         out_valid_q;
  logic [bmmd_pkg::RegionW-1:0] region_q;
  logic [bmmd_pkg::OffsetW-1:0] offset_q;
  logic                         error_q;

  bmmd_pkg::region_e            dec_region;
  logic [bmmd_pkg::OffsetW-1:0] dec_offset;
  logic                         dec_error;

  logic out_ready;
  logic req_ready;
  logic in_fire;
  logic req_fire;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign req_fire  = req_valid_q && out_ready;
  assign req_ready = !req_valid_q || out_ready;
  assign in_fire   = in_valid_i && req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bmmd_pkg::CfgColorMode: cfg_q.color_mode        <= cfg_data_i[0];
        bmmd_pkg::CfgBankCtrl:  cfg_q.bank_ctrl_present <= cfg_data_i[0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ready) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q <= req_type_i;
      addr_q     <= addr_i;
      boot_q     <= boot_overlay_on_i;
      vbank_q    <= vram_bank_i;
      wbank_q    <= wram_bank_i;
    end
  end

  bmmd_decode u_decode (
    .cfg_i             (cfg_q),
    .req_type_i        (req_type_q),
    .addr_i            (addr_q),
    .boot_overlay_on_i (boot_q),
    .vram_bank_i       (vbank_q),
    .wram_bank_i       (wbank_q),
    .region_o          (dec_region),
    .offset_o          (dec_offset),
    .error_o           (dec_error)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      region_q <= dec_region;
      offset_q <= dec_offset;
      error_q  <= dec_error;
    end
  end

  assign in_stall_o  = !req_ready;
  assign out_valid_o = out_valid_q;
  assign region_o    = region_q;
  assign offset_o    = offset_q;
  assign error_o     = error_q;

  // error flags exactly the invalid region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (error_q == (region_q == bmmd_pkg::RG_INVALID)))
    else $error("error flag disagrees with region");

  // regions with a fixed zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (error_q || region_q == bmmd_pkg::RG_DROPPED ||
                    region_q == bmmd_pkg::RG_IE) |-> offset_q == '0)
    else $error("nonzero offset for a zero-offset region");

  // stall only when both stages hold a request and the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (req_valid_q && out_valid_q && out_stall_i))
    else $error("stall raised with room in the pipeline");

  // a decoded request reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> out_valid_q)
    else $error("decoded request lost");

  // region code stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> region_q <= bmmd_pkg::RG_INVALID)
    else $error("region code out of range");

endmodule

`default_nettype wire

FILE: verif/tb_banked_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// tb_banked_memory_map_decoder
// Self-checking bench for the banked memory map decoder: every accepted
// request is decoded by a local model under the current mode settings, and
// each result leaving the block is compared field by field, in order.
// Runs a directed sweep of the map boundaries, then random requests under
// all mode settings with random sender idles and receiver stalls.
// ----------------------------------------------------------------------------
module tb_banked_memory_map_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import bmmd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  localparam logic [AddrW-1:0] VramBase     = 16'h8000;
  localparam logic [AddrW-1:0] VramBankSize = 16'h2000;
  localparam logic [AddrW-1:0] ExtRamBase   = 16'hA000;
  localparam logic [AddrW-1:0] Wram0Base    = 16'hC000;
  localparam logic [AddrW-1:0] Wram1Base    = 16'hD000;

  typedef struct packed {
    logic              req_type;
    logic [AddrW-1:0]  addr;
    logic              boot_on;
    logic              vram_bank;
    logic [WbankW-1:0] wram_bank;
  } access_t;

  typedef struct packed {
    region_e            region;
    logic [OffsetW-1:0] offset;
    logic               error;
  } decoded_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                req_type_i = 1'b0;
  logic [AddrW-1:0]    addr_i = '0;
  logic                boot_overlay_on_i = 1'b0;
  logic                vram_bank_i = 1'b0;
  logic [WbankW-1:0]   wram_bank_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [RegionW-1:0]  region_o;
  logic [OffsetW-1:0]  offset_o;
  logic                error_o;

  access_t  req_queue[$];
  decoded_t pending_results[$];
  cfg_t     mode_shadow = '0;
  logic     req_taken = 1'b0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  int       n_errors = 0;
  int       n_cycles = 0;

  banked_memory_map_decoder i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .addr_i           (addr_i),
    .boot_overlay_on_i(boot_overlay_on_i),
    .vram_bank_i      (vram_bank_i),
    .wram_bank_i      (wram_bank_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .region_o         (region_o),
    .offset_o         (offset_o),
    .error_o          (error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic decoded_t decode_access(cfg_t m, access_t r);
    decoded_t          d;
    logic [AddrW-1:0]  a;
    logic [WbankW-1:0] wb;
    d.region = RG_INVALID;
    d.offset = '0;
    d.error  = 1'b0;
    a = r.addr;
    // fold the echo area onto work RAM
    if (a >= EchoBase && a <= EchoEnd) a = a - EchoFold;
    if (r.boot_on && a <= BootLowEnd) begin
      d.region = m.color_mode ? RG_BOOT_COLOR : RG_BOOT_BASE;
      d.offset = a;
    end else if (r.boot_on && m.color_mode && a >= BootHighBase && a <= BootHighEnd) begin
      d.region = RG_BOOT_COLOR;
      d.offset = a;
    end else if (a <= RomEnd) begin
      if (m.bank_ctrl_present) begin
        d.region = RG_BANK_CTRL;
        d.offset = a;
      end else if (r.req_type == ReqWrite) begin
        d.region = RG_DROPPED;
      end else begin
        d.region = RG_CART_ROM;
        d.offset = a;
      end
    end else if (a <= VramEnd) begin
      d.region = RG_VRAM;
      d.offset = a - VramBase;
      if (m.color_mode && r.vram_bank) d.offset = d.offset + VramBankSize;
    end else if (a <= ExtRamEnd) begin
      if (m.bank_ctrl_present) begin
        d.region = RG_BANK_CTRL;
        d.offset = a;
      end else begin
        d.region = RG_EXT_RAM;
        d.offset = a - ExtRamBase;
      end
    end else if (a <= Wram0End) begin
      d.region = RG_WRAM;
      d.offset = a - Wram0Base;
    end else if (a <= Wram1End) begin
      // bank 0 reads as bank 1, and banking is off outside color mode
      wb = m.color_mode ? r.wram_bank : 3'd1;
      if (wb == 3'd0) wb = 3'd1;
      d.region = RG_WRAM;
      d.offset = {1'b0, wb, 12'h000} + (a - Wram1Base);
    end else if (a >= OamBase && a <= OamEnd) begin
      d.region = RG_OAM;
      d.offset = a - OamBase;
    end else if (a >= IoBase && a <= IoEnd) begin
      d.region = RG_IO;
      d.offset = a - IoBase;
    end else if (a >= HramBase && a <= HramEnd) begin
      d.region = RG_HRAM;
      d.offset = a - HramBase;
    end else if (a == IeAddr) begin
      d.region = RG_IE;
    end else begin
      d.error = 1'b1;
    end
    return d;
  endfunction

  function automatic logic [AddrW-1:0] pick_addr();
    logic [AddrW-1:0] marks[27];
    logic [AddrW-1:0] base;
    marks = '{16'h0000, BootLowEnd, 16'h0100, 16'h01FF, BootHighBase, BootHighEnd,
              16'h0900, RomEnd, VramBase, VramEnd, ExtRamBase, ExtRamEnd, Wram0Base,
              Wram0End, Wram1Base, Wram1End, EchoBase, EchoEnd, OamBase, OamEnd,
              16'hFEA0, 16'hFEFF, IoBase, IoEnd, HramBase, HramEnd, IeAddr};
    if ($urandom_range(1) == 0) return AddrW'($urandom);
    // land near a region boundary
    base = marks[$urandom_range(26)];
    return base + AddrW'($urandom_range(4)) - AddrW'(2);
  endfunction

  task automatic add_req(logic rt, logic [AddrW-1:0] a, logic boot, logic vb,
                         logic [WbankW-1:0] wb);
    access_t r;
    r.req_type  = rt;
    r.addr      = a;
    r.boot_on   = boot;
    r.vram_bank = vb;
    r.wram_bank = wb;
    req_queue.push_back(r);
  endtask

  task automatic add_random(int count);
    for (int i = 0; i < count; i++) begin
      add_req(1'($urandom_range(1)), pick_addr(), 1'($urandom_range(1)),
              1'($urandom_range(1)), WbankW'($urandom_range(7)));
    end
  endtask

  // hold until no request is queued, presented or in flight; look only after
  // the driver's updates at the falling edge have settled
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (req_queue.size() != 0 || in_valid_i || pending_results.size() != 0);
  endtask

  task automatic set_mode(logic color, logic bctl);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgColorMode;
    cfg_data_i <= color;
    @(negedge clk_i);
    cfg_idx_i  <= CfgBankCtrl;
    cfg_data_i <= bctl;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mode_shadow.color_mode        = color;
    mode_shadow.bank_ctrl_present = bctl;
  endtask

  task automatic run_phase(logic color, logic bctl, int idle, int stall, int count);
    wait_drained();
    set_mode(color, bctl);
    send_idle_pct = idle;
    stall_pct     = stall;
    add_random(count);
  endtask

  // driver: advance to the next request only once the current one is taken
  always @(negedge clk_i) begin : drive
    access_t r;
    if (!in_valid_i || req_taken) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = req_queue.pop_front();
        in_valid_i        <= 1'b1;
        req_type_i        <= r.req_type;
        addr_i            <= r.addr;
        boot_overlay_on_i <= r.boot_on;
        vram_bank_i       <= r.vram_bank;
        wram_bank_i       <= r.wram_bank;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // monitor: predict on acceptance, check on delivery
  always @(posedge clk_i) begin : watch
    access_t  r;
    decoded_t exp_res;
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      r.req_type  = req_type_i;
      r.addr      = addr_i;
      r.boot_on   = boot_overlay_on_i;
      r.vram_bank = vram_bank_i;
      r.wram_bank = wram_bank_i;
      pending_results.push_back(decode_access(mode_shadow, r));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result region %0d offset %0h error %0b",
                 $time, region_o, offset_o, error_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (region_o !== exp_res.region) begin
          n_errors++;
          $display("%0t: region expected %0d actual %0d", $time, exp_res.region, region_o);
        end
        if (offset_o !== exp_res.offset) begin
          n_errors++;
          $display("%0t: offset expected %0h actual %0h", $time, exp_res.offset, offset_o);
        end
        if (error_o !== exp_res.error) begin
          n_errors++;
          $display("%0t: error expected %0b actual %0b", $time, exp_res.error, error_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed sweep of the map edges in color mode without a controller
    set_mode(1'b1, 1'b0);
    add_req(ReqRead,  16'h0000, 1'b1, 1'b0, 3'd0);
    add_req(ReqRead,  BootLowEnd, 1'b1, 1'b1, 3'd7);
    add_req(ReqRead,  16'h0100, 1'b1, 1'b0, 3'd0);  // cartridge header gap
    add_req(ReqRead,  BootHighBase, 1'b1, 1'b0, 3'd0);
    add_req(ReqRead,  BootHighEnd, 1'b1, 1'b0, 3'd0);
    add_req(ReqRead,  16'h0900, 1'b1, 1'b0, 3'd0);
    add_req(ReqWrite, 16'h0000, 1'b1, 1'b0, 3'd0);
    add_req(ReqWrite, RomEnd, 1'b0, 1'b0, 3'd0);    // dropped ROM write
    add_req(ReqRead,  RomEnd, 1'b0, 1'b1, 3'd0);
    add_req(ReqRead,  VramBase, 1'b0, 1'b0, 3'd0);
    add_req(ReqWrite, VramEnd, 1'b0, 1'b1, 3'd0);
    add_req(ReqRead,  ExtRamBase, 1'b0, 1'b0, 3'd0);
    add_req(ReqWrite, ExtRamEnd, 1'b0, 1'b0, 3'd0);
    add_req(ReqRead,  Wram0Base, 1'b0, 1'b0, 3'd0);
    add_req(ReqRead,  Wram0End, 1'b0, 1'b0, 3'd7);
    add_req(ReqRead,  Wram1Base, 1'b0, 1'b0, 3'd0);
    add_req(ReqWrite, Wram1End, 1'b0, 1'b0, 3'd7);
    add_req(ReqRead,  EchoBase, 1'b1, 1'b0, 3'd3);
    add_req(ReqRead,  EchoEnd, 1'b0, 1'b0, 3'd5);
    add_req(ReqRead,  OamBase, 1'b0, 1'b0, 3'd0);
    add_req(ReqRead,  16'hFEA0, 1'b0, 1'b0, 3'd0);
    add_req(ReqWrite, 16'hFEFF, 1'b0, 1'b0, 3'd0);
    add_req(ReqRead,  IoEnd, 1'b0, 1'b0, 3'd0);
    add_req(ReqRead,  HramBase, 1'b0, 1'b0, 3'd0);
    add_req(ReqWrite, IeAddr, 1'b0, 1'b0, 3'd0);

    run_phase(1'b0, 1'b0, 0, 0, 150);
    run_phase(1'b1, 1'b1, 60, 0, 150);
    run_phase(1'b0, 1'b1, 0, 60, 150);
    run_phase(1'b1, 1'b0, 7, 7, 150);
    run_phase(1'b0, 1'b0, 60, 60, 150);

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/bmmd_pkg.sv
rtl/core/bmmd_decode.sv
rtl/core/banked_memory_map_decoder.sv
verif/tb_banked_memory_map_decoder.sv
